// ----- design/pnrm_pkg.sv -----
// ----------------------------------------------------------------------------
// pnrm_pkg
// Shared types and constants for the path slash/dot normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pnrm_pkg;

    // Path separator and dot bytes
    localparam logic [7:0] SLASH_CH = 8'h2F;
    localparam logic [7:0] DOT_CH   = 8'h2E;

    // Most result items one input byte can produce
    localparam int MAX_RES = 3;

    // Count of result items, 0 .. MAX_RES
    typedef logic [$clog2(MAX_RES+1)-1:0] t_cnt;

    // Index into the result buffer
    typedef logic [$clog2(MAX_RES)-1:0] t_idx;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_item;

    // Normalizer state carried from byte to byte
    typedef struct packed {
        logic slash_held;
        logic dot_held;
        logic emitted_any;
    } t_state;

    // Everything one input byte produces
    typedef struct packed {
        t_item [MAX_RES-1:0] items;
        t_cnt                count;
        t_state              nxt;
    } t_step;

endpackage

`default_nettype wire

// ----- design/pnrm_step.sv -----
// ----------------------------------------------------------------------------
// pnrm_step
// Per-byte decision logic: next state and up to three result items.
// ----------------------------------------------------------------------------
`default_nettype none

module pnrm_step (
    input  var pnrm_pkg::t_state i_state,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    output pnrm_pkg::t_step      o_step
);
    import pnrm_pkg::*;

    t_item [MAX_RES-1:0] items;
    t_cnt                n;
    t_state              st;
    t_idx                last_idx;

    always_comb begin
        items    = '0;
        n        = '0;
        st       = i_state;
        last_idx = '0;

        if (i_state.dot_held) begin
            if (i_byte == SLASH_CH) begin
                // fold "/./": keep the slash held
                st.dot_held = 1'b0;
            end else begin
                // release held "/." and the new byte
                items[0]       = '{data: SLASH_CH, valid: 1'b1, last: 1'b0};
                items[1]       = '{data: DOT_CH,   valid: 1'b1, last: 1'b0};
                items[2]       = '{data: i_byte,   valid: 1'b1, last: 1'b0};
                n              = t_cnt'(3);
                st.slash_held  = 1'b0;
                st.dot_held    = 1'b0;
                st.emitted_any = 1'b1;
            end
        end else if (i_state.slash_held) begin
            if (i_byte == SLASH_CH) begin
                // collapse slash run
            end else if (i_byte == DOT_CH) begin
                st.dot_held = 1'b1;
            end else begin
                items[0]       = '{data: SLASH_CH, valid: 1'b1, last: 1'b0};
                items[1]       = '{data: i_byte,   valid: 1'b1, last: 1'b0};
                n              = t_cnt'(2);
                st.slash_held  = 1'b0;
                st.emitted_any = 1'b1;
            end
        end else begin
            if (i_byte == SLASH_CH) begin
                st.slash_held = 1'b1;
            end else begin
                items[0]       = '{data: i_byte, valid: 1'b1, last: 1'b0};
                n              = t_cnt'(1);
                st.emitted_any = 1'b1;
            end
        end

        if (i_last) begin
            // keep a trailing slash only when it is the whole result
            if (st.slash_held && !st.emitted_any) begin
                items[t_idx'(n)] = '{data: SLASH_CH, valid: 1'b1, last: 1'b0};
                n                = n + t_cnt'(1);
            end
            // end-only item when nothing was produced
            if (n == '0) begin
                items[0] = '{data: 8'h00, valid: 1'b0, last: 1'b0};
                n        = t_cnt'(1);
            end
            last_idx             = t_idx'(n - t_cnt'(1));
            items[last_idx].last = 1'b1;
            st                   = '0;
        end
    end

    assign o_step = '{items: items, count: n, nxt: st};

endmodule

`default_nettype wire

// ----- design/path_slash_dot_normalizer.sv -----
// ----------------------------------------------------------------------------
// path_slash_dot_normalizer
// Streaming path normalizer: collapses slash runs and folds "/./" segments.
// ----------------------------------------------------------------------------
// Takes one path byte per request on the slave side (tlast on the final byte)
// and sends the normalized path on the master side, one byte per request,
// with tlast on the final item of each path. An item with tuser low carries no
// byte and only ends the path. Each input byte yields zero to three result
// items; they sit in a three-entry result buffer that drains one item per
// cycle while the master side is ready. A new byte is taken whenever the
// buffer empties in that cycle, so bytes that produce at most one item flow
// at one per cycle while the master side is ready, and a byte that releases
// two or three items stalls the input while the buffer drains.
`default_nettype none

module path_slash_dot_normalizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input path bytes
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // in_last
    // normalized path bytes
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tuser,   // [0] byte_valid
    output logic            o_m_axis_tlast    // path_end
);
    import pnrm_pkg::*;

    t_state              r_state;
    t_item [MAX_RES-1:0] r_items;
    t_idx                r_head;
    t_cnt                r_cnt;

    t_step               step;
    t_item               head_item;
    logic                pop;
    logic                accept;

    pnrm_step u_step (
        .i_state (r_state),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_step  (step)
    );

    // drive the master side from the buffer head
    assign head_item       = r_items[r_head];
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = head_item.data;
    assign o_m_axis_tuser  = head_item.valid;
    assign o_m_axis_tlast  = head_item.last;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;

    // take a request when the buffer is empty by the end of this cycle
    assign o_s_axis_tready = (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // advance state and buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_head  <= '0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_state <= step.nxt;
                r_head  <= '0;
                r_cnt   <= step.count;
            end else if (pop) begin
                r_head  <= r_head + t_idx'(1);
                r_cnt   <= r_cnt - t_cnt'(1);
            end
        end
    end

    // load result items
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_items <= step.items;
        end
    end

endmodule

`default_nettype wire
